// ===== hdl/sta_pkg.sv =====
// Shared types, constants and helpers for the signed-to-ASCII radix converter.
package sta_pkg;

	localparam int VAL_W           = 32;
	localparam int BASE_W          = 6;
	localparam int CHAR_W          = 7;
	localparam int MAX_RESULTS     = 32;
	localparam int DIGIT_SLOTS_DEF = 32;

	localparam logic [BASE_W-1:0] MIN_BASE = BASE_W'(2);
	localparam logic [BASE_W-1:0] MAX_BASE = BASE_W'(32);
	localparam logic [BASE_W-1:0] DEC_BASE = BASE_W'(10);

	localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(45);
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);
	localparam logic [CHAR_W-1:0] CHAR_ALPHA = CHAR_W'(65);
	localparam logic [CHAR_W-1:0] CHAR_NONE  = CHAR_W'(0);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_SIGN,
		S_READ,
		S_LOAD
	} sta_state_t;

	typedef struct packed {
		logic              done;
		logic [VAL_W-1:0]  quo;
		logic [BASE_W-1:0] rem;
	} div_res_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [BASE_W-1:0] d);
		logic [CHAR_W-1:0] dw;
		dw = CHAR_W'(d);
		if (d >= DEC_BASE) begin
			return CHAR_ALPHA + dw - CHAR_W'(DEC_BASE);
		end
		return CHAR_ZERO + dw;
	endfunction

endpackage

// ===== hdl/sta_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle, 32-bit dividend by 6-bit divisor.
module sta_div import sta_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [VAL_W-1:0]  dividend,
	input  logic [BASE_W-1:0] divisor,
	output div_res_t          res
);

	localparam int CNT_W = $clog2(VAL_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [VAL_W-1:0]  quo_q;
	logic [BASE_W-1:0] rem_q;
	logic [BASE_W-1:0] dvs_q;
	logic [BASE_W:0]   trial;
	logic              qbit;
	logic [BASE_W-1:0] rem_d;

	always_comb begin
		trial = {rem_q, quo_q[VAL_W-1]};
		qbit  = trial >= {1'b0, dvs_q};
		rem_d = qbit ? BASE_W'(trial - {1'b0, dvs_q}) : trial[BASE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(VAL_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[VAL_W-2:0], qbit};
			rem_q <= rem_d;
		end
	end

	assign res.done = done_q;
	assign res.quo  = quo_q;
	assign res.rem  = rem_q;

endmodule

// ===== hdl/sta_stack.sv =====
// Character buffer: digits written least significant first, read back in reverse.
module sta_stack import sta_pkg::*; #(
	parameter int DEPTH = MAX_RESULTS
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [CHAR_W-1:0]        wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [CHAR_W-1:0]        rd_data
);

	logic [CHAR_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hdl/signed_to_ascii_radix.sv =====
// Top level: signed integer to ASCII text in base 2..32, one character per item.
// Each accepted value is converted to characters, most significant first, with last set on the
// final one; negative values get a leading '-' only in base 10, and a base outside 2..32 gives
// one item with bad_base set and char_code 0. Each digit of a valid value comes from the shared
// bit-serial divider (one quotient bit per cycle over all 32 dividend bits); a sign takes a step
// of its own, and each character is read out of the buffer memory and then loaded into the
// output register, which waits while a held character has not been taken.
// The block takes a new value only when the previous one is fully delivered.
module signed_to_ascii_radix import sta_pkg::*; #(
	parameter int DIGIT_SLOTS = DIGIT_SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [VAL_W-1:0]  value,
	input  logic [BASE_W-1:0] base,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [CHAR_W-1:0] char_code,
	output logic              last,
	output logic              bad_base
);

	localparam int SLOT_LIM = (DIGIT_SLOTS > MAX_RESULTS) ? MAX_RESULTS : DIGIT_SLOTS;
	localparam int AW       = $clog2(SLOT_LIM);
	localparam int CW       = $clog2(SLOT_LIM + 1);

	sta_state_t        state_q, state_d;
	logic [CW-1:0]     n_q, n_d;
	logic [BASE_W-1:0] base_q;
	logic              dneg_q;
	logic              out_valid_q;
	logic [CHAR_W-1:0] char_q;
	logic              last_q;
	logic              bad_q;

	logic              in_acc;
	logic              base_ok;
	logic [VAL_W-1:0]  mag;
	logic              div_start;
	logic [VAL_W-1:0]  div_dividend;
	div_res_t          div_res;
	logic              push;
	logic [CHAR_W-1:0] push_char;
	logic              pop;
	logic [AW-1:0]     pop_addr;
	logic [CHAR_W-1:0] rd_char;
	logic              load_out;
	logic [CHAR_W-1:0] char_d;
	logic              last_d;
	logic              bad_d;
	logic              take_in;

	assign in_ready = (state_q == S_IDLE) && !out_valid_q;
	assign in_acc   = in_valid && in_ready;
	assign base_ok  = (base >= MIN_BASE) && (base <= MAX_BASE);
	assign mag      = value[VAL_W-1] ? (VAL_W'(0) - value) : value;
	assign pop_addr = AW'(n_q - CW'(1));

	sta_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (take_in ? base : base_q),
		.res      (div_res)
	);

	sta_stack #(
		.DEPTH (SLOT_LIM)
	) u_stack (
		.clk     (clk),
		.wr_en   (push),
		.wr_addr (n_q[AW-1:0]),
		.wr_data (push_char),
		.rd_en   (pop),
		.rd_addr (pop_addr),
		.rd_data (rd_char)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		n_d          = n_q;
		take_in      = 1'b0;
		div_start    = 1'b0;
		div_dividend = div_res.quo;
		push         = 1'b0;
		push_char    = digit_char(div_res.rem);
		pop          = 1'b0;
		load_out     = 1'b0;
		char_d       = rd_char;
		last_d       = (n_q == '0);
		bad_d        = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					if (base_ok) begin
						take_in      = 1'b1;
						div_start    = 1'b1;
						div_dividend = mag;
						n_d          = '0;
						state_d      = S_DIV;
					end else begin
						load_out = 1'b1;
						char_d   = CHAR_NONE;
						last_d   = 1'b1;
						bad_d    = 1'b1;
					end
				end
			end
			S_DIV: begin
				if (div_res.done) begin
					if (n_q < CW'(SLOT_LIM)) begin
						push = 1'b1;
						n_d  = n_q + CW'(1);
					end
					if (div_res.quo != '0) begin
						div_start = 1'b1;
					end else if (dneg_q) begin
						state_d = S_SIGN;
					end else begin
						state_d = S_READ;
					end
				end
			end
			S_SIGN: begin
				push_char = CHAR_MINUS;
				if (n_q < CW'(SLOT_LIM)) begin
					push = 1'b1;
					n_d  = n_q + CW'(1);
				end
				state_d = S_READ;
			end
			S_READ: begin
				pop     = 1'b1;
				n_d     = n_q - CW'(1);
				state_d = S_LOAD;
			end
			S_LOAD: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = (n_q == '0) ? S_IDLE : S_READ;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			n_q <= n_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			base_q <= base;
			dneg_q <= value[VAL_W-1] && (base == DEC_BASE);
		end
		if (load_out) begin
			char_q <= char_d;
			last_q <= last_d;
			bad_q  <= bad_d;
		end
	end

	assign out_valid = out_valid_q;
	assign char_code = char_q;
	assign last      = last_q;
	assign bad_base  = bad_q;

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= CW'(SLOT_LIM))
		else $error("character count above slot limit");

	a_div_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> state_q == S_DIV)
		else $error("divider result outside digit phase");

	a_err_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_base |-> last && (char_code == CHAR_NONE))
		else $error("error item malformed");

	a_good_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && base_ok |=> state_q == S_DIV)
		else $error("valid item did not start conversion");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_READ |-> n_q != '0)
		else $error("read from empty character buffer");
`endif

endmodule
